/* rtl/irde_pkg.sv */
// Shared types, constants and lookup functions for the IR ring direction estimator.
// Depends on nothing; irde_counters, irde_scan and the top level import it.
package irde_pkg;

	// Receiver ring geometry and counter width.
	localparam int NUM_RX      = 12;
	localparam int COUNT_WIDTH = 16;
	localparam int IDX_WIDTH   = $clog2(NUM_RX);
	localparam int PEAK_WIDTH  = 16;
	localparam int ANGLE_WIDTH = 9;
	localparam int CLASS_WIDTH = 2;
	localparam int WORD_WIDTH  = 13;
	localparam int THR_WIDTH   = 6;

	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [IDX_WIDTH-1:0]   idx_t;
	typedef logic [PEAK_WIDTH-1:0]  peak_t;
	typedef logic [ANGLE_WIDTH-1:0] angle_t;
	typedef logic [CLASS_WIDTH-1:0] class_t;
	typedef logic [WORD_WIDTH-1:0]  word_t;
	typedef logic [THR_WIDTH-1:0]   thr_t;
	typedef count_t                 count_arr_t [NUM_RX];

	localparam count_t COUNT_MAX = '1;
	localparam peak_t  PEAK_MAX  = '1;
	localparam idx_t   IDX_LAST  = idx_t'(NUM_RX - 1);

	// Distance grades.
	localparam class_t CLS_NONE = 2'd0;
	localparam class_t CLS_FAR  = 2'd1;
	localparam class_t CLS_MID  = 2'd2;
	localparam class_t CLS_NEAR = 2'd3;

	// Control from the scan sequencer to the counter bank.
	typedef struct packed {
		logic clear;
	} cnt_ctrl_t;

	// Angle of each receiver in degrees.
	function automatic angle_t rx_angle(input idx_t idx);
		angle_t a;
		case (idx)
			4'd0:    a = 9'd0;
			4'd1:    a = 9'd330;
			4'd2:    a = 9'd30;
			4'd3:    a = 9'd300;
			4'd4:    a = 9'd60;
			4'd5:    a = 9'd270;
			4'd6:    a = 9'd90;
			4'd7:    a = 9'd240;
			4'd8:    a = 9'd120;
			4'd9:    a = 9'd210;
			4'd10:   a = 9'd150;
			4'd11:   a = 9'd180;
			default: a = 9'd0;
		endcase
		return a;
	endfunction

	// Near threshold per receiver group.
	function automatic thr_t rx_near(input idx_t idx);
		thr_t t;
		if (idx == 4'd0) begin
			t = 6'd50;
		end else if (idx <= 4'd4) begin
			t = 6'd35;
		end else if (idx <= 4'd6) begin
			t = 6'd45;
		end else begin
			t = 6'd40;
		end
		return t;
	endfunction

	// Middle threshold per receiver group.
	function automatic thr_t rx_mid(input idx_t idx);
		thr_t t;
		if (idx == 4'd0) begin
			t = 6'd35;
		end else if (idx <= 4'd4) begin
			t = 6'd25;
		end else if (idx <= 4'd6) begin
			t = 6'd35;
		end else begin
			t = 6'd30;
		end
		return t;
	endfunction

	// Thousands part of the encoded word for each grade.
	function automatic word_t class_base(input class_t cls);
		word_t b;
		case (cls)
			CLS_NONE: b = 13'd2000;
			CLS_FAR:  b = 13'd3000;
			CLS_MID:  b = 13'd4000;
			CLS_NEAR: b = 13'd5000;
			default:  b = 13'd2000;
		endcase
		return b;
	endfunction

endpackage

/* rtl/irde_sample_if.sv */
// Sample channel: valid/ready handshake carrying one sample of the receiver ring.
// Depends on nothing.
interface irde_sample_if;
	logic        valid;
	logic        ready;
	logic [11:0] sensor_levels;
	logic        last_sample;

	modport source (output valid, output sensor_levels, output last_sample, input ready);
	modport sink (input valid, input sensor_levels, input last_sample, output ready);
endinterface

/* rtl/irde_result_if.sv */
// Result channel: valid/ready handshake carrying one direction estimate.
// Depends on nothing.
interface irde_result_if;
	logic        valid;
	logic        ready;
	logic [8:0]  angle;
	logic [1:0]  distance_class;
	logic [12:0] encoded_word;
	logic [15:0] peak_count;

	modport source (output valid, output angle, output distance_class,
		output encoded_word, output peak_count, input ready);
	modport sink (input valid, input angle, input distance_class,
		input encoded_word, input peak_count, output ready);
endinterface

/* rtl/irde_counters.sv */
// Bank of saturating per-receiver hit counters.
// Depends on irde_pkg.
module irde_counters import irde_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         inc_en,
	input  logic [11:0]  levels,
	input  cnt_ctrl_t    ctrl,
	output count_arr_t   counts
);

	count_arr_t counts_q;

	// Each receiver read low counts once per accepted word, holding at full scale.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_RX; i++) begin
				counts_q[i] <= '0;
			end
		end else if (ctrl.clear) begin
			for (int i = 0; i < NUM_RX; i++) begin
				counts_q[i] <= '0;
			end
		end else if (inc_en) begin
			for (int i = 0; i < NUM_RX; i++) begin
				if (!levels[i] && counts_q[i] != COUNT_MAX) begin
					counts_q[i] <= counts_q[i] + count_t'(1);
				end
			end
		end
	end

	assign counts = counts_q;

endmodule

/* rtl/irde_scan.sv */
// Window-end sequencer: one shared comparator walks the counters, then grades the peak.
// Depends on irde_pkg and irde_result_if.
module irde_scan import irde_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  count_arr_t           counts,
	output logic                 idle,
	output cnt_ctrl_t            ctrl,
	irde_result_if.source        result
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_GRADE = 2'd2;

	logic [1:0] state_q;
	idx_t       idx_q;
	idx_t       best_q;
	count_t     peak_q;
	logic       found_q;

	logic       out_valid_q;
	angle_t     angle_q;
	class_t     class_q;
	word_t      word_q;
	peak_t      peak_out_q;

	count_t     cur;
	logic       slot_free;
	logic       emit;
	angle_t     g_angle;
	class_t     g_class;
	peak_t      g_peak;

	assign cur       = counts[idx_q];
	assign slot_free = !out_valid_q || result.ready;
	assign emit      = (state_q == ST_GRADE) && slot_free;

	// Grade the winning receiver against its group's thresholds, or CLS_NONE if none won.
	always_comb begin
		if (!found_q) begin
			g_angle = '0;
			g_class = CLS_NONE;
		end else begin
			g_angle = rx_angle(best_q);
			if (peak_q > count_t'(rx_near(best_q))) begin
				g_class = CLS_NEAR;
			end else if (peak_q > count_t'(rx_mid(best_q))) begin
				g_class = CLS_MID;
			end else begin
				g_class = CLS_FAR;
			end
		end
		if (peak_q > count_t'(PEAK_MAX)) begin
			g_peak = PEAK_MAX;
		end else begin
			g_peak = peak_t'(peak_q);
		end
	end

	// Sequencer: scan one counter per cycle, keep the first strict maximum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			best_q  <= '0;
			peak_q  <= '0;
			found_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SCAN;
						idx_q   <= '0;
						peak_q  <= '0;
						best_q  <= '0;
						found_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (cur > peak_q) begin
						peak_q  <= cur;
						best_q  <= idx_q;
						found_q <= 1'b1;
					end
					if (idx_q == IDX_LAST) begin
						state_q <= ST_GRADE;
					end else begin
						idx_q <= idx_q + idx_t'(1);
					end
				end
				ST_GRADE: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register: holds the word until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			angle_q    <= g_angle;
			class_q    <= g_class;
			word_q     <= class_base(g_class) + word_t'(g_angle);
			peak_out_q <= g_peak;
		end
	end

	assign idle                  = (state_q == ST_IDLE);
	assign ctrl.clear            = emit;
	assign result.valid          = out_valid_q;
	assign result.angle          = angle_q;
	assign result.distance_class = class_q;
	assign result.encoded_word   = word_q;
	assign result.peak_count     = peak_out_q;

endmodule

/* rtl/ir_ring_direction_estimator_core.sv */
// Top level of the IR ring direction estimator: counter bank plus scan sequencer.
// Depends on irde_pkg, irde_sample_if, irde_result_if, irde_counters and irde_scan.

// Each sample word lands on twelve saturating counters at once, so ordinary
// samples are taken back to back. A word marked last_sample is counted and then
// closes the window: one shared comparator walks the twelve counters, one per
// cycle, and the grading state follows; the sample port stays not ready through
// the scan and the grading, which lasts longer if the previous result has not been
// taken. The counters clear as the result word is loaded into the output
// register, and a finished result may wait there while new samples are counted.
module ir_ring_direction_estimator_core import irde_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	irde_sample_if.sink   samples,
	irde_result_if.source result
);

	logic       idle;
	logic       accept;
	cnt_ctrl_t  ctrl;
	count_arr_t counts;

	// Samples are taken only while no window is being closed.
	assign samples.ready = idle;
	assign accept        = samples.valid && idle;

	irde_counters u_counters (
		.clk    (clk),
		.arst_n (arst_n),
		.inc_en (accept),
		.levels (samples.sensor_levels),
		.ctrl   (ctrl),
		.counts (counts)
	);

	irde_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && samples.last_sample),
		.counts (counts),
		.idle   (idle),
		.ctrl   (ctrl),
		.result (result)
	);

endmodule
